// ----- hw/rtl/rptw_pkg.sv -----
// Shared constants and types for the radix page table walker.
`timescale 1ns / 1ps
`default_nettype none
package rptw_pkg;

  localparam int FRAME_BITS = 6;
  localparam int FRAMES     = 1 << FRAME_BITS;
  localparam int LEVELS     = 5;
  localparam int INDEX_BITS = 9;
  localparam int VPN_W      = LEVELS * INDEX_BITS;
  localparam int PPN_W      = 52;
  localparam int ENTRY_W    = PPN_W + 1;
  localparam int ADDR_W     = FRAME_BITS + INDEX_BITS;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int ROOT_W     = 6;
  localparam int FREE_W     = 7;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic REG_ROOT_FRAME = 1'b0;
  localparam logic REG_FIRST_FREE = 1'b1;

  typedef struct packed {
    logic [ROOT_W-1:0] root_frame;
    logic              load_free;
    logic [FREE_W-1:0] free_value;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rptw_cfg.sv -----
// APB configuration registers: root frame and allocator start.
`timescale 1ns / 1ps
`default_nettype none
module rptw_cfg (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [rptw_pkg::PADDR_W-1:0]  paddr,
  input  wire [rptw_pkg::PDATA_W-1:0]  pwdata,
  output logic [rptw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output rptw_pkg::cfg_t               cfg
);
  import rptw_pkg::*;

  logic [ROOT_W-1:0] root_frame;
  logic [FREE_W-1:0] first_free_frame;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame       <= '0;
      first_free_frame <= FREE_W'(1);
    end else if (wr) begin
      if (paddr[2] == REG_ROOT_FRAME) begin
        root_frame <= pwdata[ROOT_W-1:0];
      end else begin
        first_free_frame <= pwdata[FREE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_ROOT_FRAME) begin
      prdata = {{(PDATA_W-ROOT_W){1'b0}}, root_frame};
    end else begin
      prdata = {{(PDATA_W-FREE_W){1'b0}}, first_free_frame};
    end
  end

  // allocator reloads on the same edge the register takes the word
  assign cfg.root_frame = root_frame;
  assign cfg.load_free  = wr && (paddr[2] == REG_FIRST_FREE);
  assign cfg.free_value = pwdata[FREE_W-1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/radix_page_table_walker_top.sv -----
// Radix page table walker: sequencer, frame store and result register.
// Each level visited takes a store read (S_RD) and then a check/update (S_CHK);
//   S_FIN then loads the output register.
// The walker takes one word at a time and finishes its walk first; the next word
//   is taken the cycle after the result loads, and a stalled result holds the walk.
// Reset: synchronous; a clearing pass writes zero to all FRAMES*512 store
//   entries with in_stall high; config writes are still taken.
`timescale 1ns / 1ps
`default_nettype none
module radix_page_table_walker_top (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          cmd,
  input  wire [rptw_pkg::VPN_W-1:0]    vpn,
  input  wire [rptw_pkg::PPN_W-1:0]    ppn,
  input  wire                          unmap,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         found,
  output logic [rptw_pkg::PPN_W-1:0]   mapped_page,
  output logic                         out_of_frames,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [rptw_pkg::PADDR_W-1:0]  paddr,
  input  wire [rptw_pkg::PDATA_W-1:0]  pwdata,
  output logic [rptw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import rptw_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  cfg_t cfg;

  rptw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [2:0]            state;
  logic [ADDR_W-1:0]     clr_cnt;
  logic [FREE_W-1:0]     next_free;
  logic                  upd;
  logic                  unmap_r;
  logic [VPN_W-1:0]      vpn_sh;
  logic [PPN_W-1:0]      ppn_r;
  logic [FRAME_BITS-1:0] frame;
  logic [LVL_W-1:0]      level;
  logic [ADDR_W-1:0]     slot;
  logic [ENTRY_W-1:0]    rdata;
  logic                  res_found;
  logic [PPN_W-1:0]      res_page;
  logic                  res_oof;

  logic [ENTRY_W-1:0]    mem [DEPTH];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic [ADDR_W-1:0]     slot_c;
  logic                  leaf;
  logic                  ent_valid;
  logic                  no_frames;
  logic                  alloc;
  logic                  in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_c    = {frame, vpn_sh[VPN_W-1 -: INDEX_BITS]};
  assign leaf      = (level == LVL_W'(LEVELS - 1));
  assign ent_valid = rdata[0];
  assign no_frames = (next_free >= FREE_W'(FRAMES));
  assign alloc     = (state == S_CHK) && !leaf && !ent_valid && upd && !unmap_r && !no_frames;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
    end else if (alloc) begin
      mem_we    = 1'b1;
      mem_wdata = {{(PPN_W-FREE_W){1'b0}}, next_free, 1'b1};
    end else if (state == S_CHK && leaf && upd) begin
      mem_we    = 1'b1;
      mem_wdata = unmap_r ? '0 : {ppn_r, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_RD) begin
      rdata <= mem[slot_c];
    end
  end

  // allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= FREE_W'(1);
    end else if (cfg.load_free) begin
      next_free <= cfg.free_value;
    end else if (alloc) begin
      next_free <= next_free + FREE_W'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == {ADDR_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            upd     <= (cmd == CMD_UPDATE);
            unmap_r <= unmap;
            vpn_sh  <= vpn;
            ppn_r   <= ppn;
            frame   <= cfg.root_frame[FRAME_BITS-1:0];
            level   <= '0;
            state   <= S_RD;
          end
        end
        S_RD: begin
          slot  <= slot_c;
          state <= S_CHK;
        end
        S_CHK: begin
          res_found <= 1'b0;
          res_page  <= '0;
          res_oof   <= 1'b0;
          if (leaf) begin
            if (!upd && ent_valid) begin
              res_found <= 1'b1;
              res_page  <= rdata[ENTRY_W-1:1];
            end
            state <= S_FIN;
          end else if (ent_valid) begin
            frame  <= rdata[FRAME_BITS:1];
            level  <= level + LVL_W'(1);
            vpn_sh <= vpn_sh << INDEX_BITS;
            state  <= S_RD;
          end else if (!upd || unmap_r) begin
            state <= S_FIN;
          end else if (no_frames) begin
            res_oof <= 1'b1;
            state   <= S_FIN;
          end else begin
            frame  <= next_free[FRAME_BITS-1:0];
            level  <= level + LVL_W'(1);
            vpn_sh <= vpn_sh << INDEX_BITS;
            state  <= S_RD;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            found         <= res_found;
            mapped_page   <= res_page;
            out_of_frames <= res_oof;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_alloc_has_frame: assert property (@(posedge clk) disable iff (rst)
    alloc |-> (next_free < FREE_W'(FRAMES)))
    else $error("frame allocated with allocator exhausted");

  a_free_monotonic: assert property (@(posedge clk) disable iff (rst)
    !cfg.load_free |=> (next_free >= $past(next_free)))
    else $error("allocator moved backward without a reload");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_CHK))
    else $error("frame store written outside clear or check");

  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && out_of_frames))
    else $error("result both found and out of frames");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_CHK) |-> (level <= LVL_W'(LEVELS - 1)))
    else $error("walk level beyond leaf");

endmodule
`default_nettype wire

// ----- tb/rptw_walk_checker.sv -----
// Checker for the radix page table walker: mirrors the page tables and compares result words.
`timescale 1ns / 1ps
module rptw_walk_checker
  import rptw_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_stall,
  input  wire                cmd,
  input  wire [VPN_W-1:0]    vpn,
  input  wire [PPN_W-1:0]    ppn,
  input  wire                unmap,
  input  wire                out_valid,
  input  wire                out_stall,
  input  wire                found,
  input  wire [PPN_W-1:0]    mapped_page,
  input  wire                out_of_frames,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [PADDR_W-1:0]  paddr,
  input  wire [PDATA_W-1:0]  pwdata,
  input  wire                pready,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic             found;
    logic [PPN_W-1:0] page;
    logic             out_of_frames;
  } walk_result_t;

  logic [ENTRY_W-1:0] table_mem [DEPTH];
  logic [ROOT_W-1:0]  root_sel;
  logic [FREE_W-1:0]  next_alloc;
  walk_result_t       walk_results_q [$];
  int                 mismatch_count = 0;
  int                 words_pending = 0;

  assign mismatches  = mismatch_count;
  assign outstanding = words_pending;

  // Walks the mirrored tables; map updates allocate missing interior frames and write the leaf, unmaps clear it.
  function automatic walk_result_t walk(logic op, logic [VPN_W-1:0] va,
                                        logic [PPN_W-1:0] pa, logic drop);
    walk_result_t          r;
    logic [FRAME_BITS-1:0] frame;
    logic [ADDR_W-1:0]     slot;
    logic                  is_update;
    r = '0;
    is_update = (op == CMD_UPDATE);
    frame = root_sel;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      slot = {frame, va[(LEVELS-1-lvl)*INDEX_BITS +: INDEX_BITS]};
      if (!table_mem[slot][0]) begin
        if (!is_update || drop) return r;
        if (next_alloc >= FRAMES) begin
          r.out_of_frames = 1'b1;
          return r;
        end
        table_mem[slot] = {PPN_W'(next_alloc), 1'b1};
        next_alloc++;
      end
      // frame numbers wrap to the store size
      frame = table_mem[slot][FRAME_BITS:1];
    end
    slot = {frame, va[INDEX_BITS-1:0]};
    if (!is_update) begin
      if (table_mem[slot][0]) begin
        r.found = 1'b1;
        r.page  = table_mem[slot][ENTRY_W-1:1];
      end
    end else if (drop) begin
      table_mem[slot] = '0;
    end else begin
      table_mem[slot] = {pa, 1'b1};
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    walk_result_t want;
    if (rst) begin
      for (int a = 0; a < DEPTH; a++) table_mem[a] = '0;
      root_sel   = '0;
      next_alloc = FREE_W'(1);
      walk_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ROOT_FRAME: root_sel = pwdata[ROOT_W-1:0];
          REG_FIRST_FREE: next_alloc = pwdata[FREE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        walk_results_q.push_back(walk(cmd, vpn, ppn, unmap));
      if (out_valid && !out_stall) begin
        if (walk_results_q.size() == 0) begin
          $display("%0t: unexpected result word: found %0d page %h out_of_frames %0d",
                   $time, found, mapped_page, out_of_frames);
          mismatch_count++;
        end else begin
          want = walk_results_q.pop_front();
          if (found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
            mismatch_count++;
          end
          if (mapped_page !== want.page) begin
            $display("%0t: mapped_page expected %h actual %h",
                     $time, want.page, mapped_page);
            mismatch_count++;
          end
          if (out_of_frames !== want.out_of_frames) begin
            $display("%0t: out_of_frames expected %0d actual %0d",
                     $time, want.out_of_frames, out_of_frames);
            mismatch_count++;
          end
        end
      end
    end
    words_pending <= walk_results_q.size();
  end

endmodule

// ----- tb/radix_page_table_walker_top_tb.sv -----
// Testbench top for the radix page table walker: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module radix_page_table_walker_top_tb;
  import rptw_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic [VPN_W-1:0]   vpn;
  logic [PPN_W-1:0]   ppn;
  logic               unmap;
  logic               out_valid;
  logic               out_stall;
  logic               found;
  logic [PPN_W-1:0]   mapped_page;
  logic               out_of_frames;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding;
  bit                 no_gaps;

  radix_page_table_walker_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .vpn(vpn), .ppn(ppn), .unmap(unmap),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .mapped_page(mapped_page), .out_of_frames(out_of_frames),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rptw_walk_checker walk_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .vpn(vpn), .ppn(ppn), .unmap(unmap),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .mapped_page(mapped_page), .out_of_frames(out_of_frames),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 26);
  end

  function automatic logic [VPN_W-1:0] rand_vpn();
    return VPN_W'({$urandom, $urandom});
  endfunction

  task automatic send_walk(input logic op, input logic [VPN_W-1:0] va,
                           input logic [PPN_W-1:0] pa, input logic drop);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    vpn      <= va;
    ppn      <= pa;
    unmap    <= drop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and hold until every predicted word has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({sel, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly walks that share prefixes with a small set of base addresses, so
  // the tables get deep; the rest is fully random noise.
  task automatic run_phase(input int root, input int first_free, input int count,
                           input bit pause_mid);
    logic [VPN_W-1:0] pool [6];
    logic [VPN_W-1:0] va;
    logic [VPN_W-1:0] mask;
    logic [PPN_W-1:0] pa;
    logic             op;
    logic             drop;
    int               lv;
    reg_write(REG_ROOT_FRAME, PDATA_W'(root));
    reg_write(REG_FIRST_FREE, PDATA_W'(first_free));
    pool[0] = '0;
    pool[1] = '1;
    for (int k = 2; k < 6; k++) pool[k] = rand_vpn();
    for (int n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) drain();
      pa = PPN_W'({$urandom, $urandom});
      op = ($urandom_range(1) == 1) ? CMD_UPDATE : CMD_QUERY;
      if ($urandom_range(99) < 72) begin
        lv   = $urandom_range(0, LEVELS);
        mask = {VPN_W{1'b1}} >> (VPN_W - INDEX_BITS * lv);
        va   = (pool[$urandom_range(0, 5)] & ~mask) | (rand_vpn() & mask);
      end else begin
        va = rand_vpn();
      end
      drop = (op == CMD_UPDATE) ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
      send_walk(op, va, pa, drop);
    end
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = CMD_QUERY;
    vpn       = '0;
    ppn       = '0;
    unmap     = 1'b0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    no_gaps   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // writes land during the clearing pass
    reg_write(REG_ROOT_FRAME, '0);
    reg_write(REG_FIRST_FREE, PDATA_W'(1));

    send_walk(CMD_QUERY, '0, '0, 1'b0);
    send_walk(CMD_UPDATE, '0, '1, 1'b0);
    send_walk(CMD_QUERY, '0, '0, 1'b0);
    send_walk(CMD_UPDATE, '1, '0, 1'b0);
    send_walk(CMD_QUERY, '1, '1, 1'b0);
    // unmap where the path was never built
    send_walk(CMD_UPDATE, {5{9'h0aa}}, '1, 1'b1);
    send_walk(CMD_UPDATE, '0, '0, 1'b1);
    send_walk(CMD_QUERY, '0, '0, 1'b0);
    send_walk(CMD_UPDATE, '0, {13{4'h5}}, 1'b0);
    send_walk(CMD_QUERY, '0, '0, 1'b1);
    send_walk(CMD_UPDATE, {{36{1'b1}}, 9'h000}, {13{4'ha}}, 1'b0);
    // fresh top-level slots until the allocator runs dry
    for (int i = 1; i <= 14; i++)
      send_walk(CMD_UPDATE, {9'(i), 36'h0}, PPN_W'(i) << 20, 1'b0);
    send_walk(CMD_QUERY, {9'd14, 36'h0}, '0, 1'b0);
    drain();

    // leaf tables walked as interior tables, no free frames
    run_phase(4, FRAMES, 60, 1'b0);
    // allocator reloaded over frames in use
    run_phase(0, 1, 60, 1'b1);
    no_gaps = 1'b1;
    // allocator hands out the root frame
    run_phase(5, 5, 60, 1'b0);
    no_gaps = 1'b0;
    run_phase(63, 40, 60, 1'b0);
    run_phase($urandom_range(0, 63), $urandom_range(1, 64), 60, 1'b0);
    run_phase(0, 60, 60, 1'b0);
    run_phase($urandom_range(0, 63), $urandom_range(1, 64), 60, 1'b0);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("radix_page_table_walker_top regression: pass");
    end else begin
      $display("radix_page_table_walker_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("radix_page_table_walker_top regression: fail");
    $finish;
  end

endmodule
